/* src/fsfa_pkg.sv */
// ----------------------------------------------------------------------------
// fsfa_pkg - shared types and constants for the flow sensor frame accumulator
// Frame format constants, request kinds, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fsfa_pkg;

	// request kind carried in s_tuser
	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_BATCH = 1'b1;

	// frame layout
	localparam logic [7:0] FRAME_HEADER = 8'hFE;
	localparam logic [7:0] FRAME_FOOTER = 8'hAA;
	localparam logic [3:0] POS_IDLE     = 4'd0;
	localparam logic [3:0] POS_X_LO     = 4'd2;
	localparam logic [3:0] POS_X_HI     = 4'd3;
	localparam logic [3:0] POS_Y_LO     = 4'd4;
	localparam logic [3:0] POS_Y_HI     = 4'd5;
	localparam logic [3:0] POS_QUAL     = 4'd7;
	localparam logic [3:0] POS_LAST     = 4'd8;

	// quality clamp window and scaling
	localparam logic [15:0] QUAL_LOW  = 16'd64;
	localparam logic [15:0] QUAL_HIGH = 16'd78;
	localparam logic [3:0]  QUAL_SPAN = 4'd14;

	// (i * 255) / 14, truncated, for i = 0..14
	localparam logic [7:0] QUAL_SCALE_TABLE [15] = '{
		8'd0,   8'd18,  8'd36,  8'd54,  8'd72,  8'd91,  8'd109, 8'd127,
		8'd145, 8'd163, 8'd182, 8'd200, 8'd218, 8'd236, 8'd255
	};

	localparam int DIV_STEPS = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take_byte;    // accepted serial byte
		logic batch_clear;  // empty batch: clear sums, no result
		logic start_div;    // load divider with quality sum / frame count
		logic div_step;     // one restoring division step
		logic load_out;     // move result to output register, clear sums
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;   // frame counter is zero
		logic div_last;     // current step is the final one
		logic out_free;     // output register can take a new result
	} dp_status_t;

endpackage

`default_nettype wire

/* src/fsfa_ctrl.sv */
// ----------------------------------------------------------------------------
// fsfa_ctrl - sequencer for the flow sensor frame accumulator
// Accepts bytes and batch requests while idle, runs the quality division
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfa_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_kind,
	output logic                 in_ready,
	input  fsfa_pkg::dp_status_t status,
	output fsfa_pkg::dp_cmd_t    cmd
);
	import fsfa_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_kind == REQ_BATCH && !status.count_zero) begin
					state_nxt = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status.div_last) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd             = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.take_byte   = accept && in_kind == REQ_BYTE;
				cmd.batch_clear = accept && in_kind == REQ_BATCH && status.count_zero;
				cmd.start_div   = accept && in_kind == REQ_BATCH && !status.count_zero;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_EMIT: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// a batch with frames must always leave idle for the division
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |=> state_q == ST_DIVIDE)
		else $error("division did not start after batch request");

	// no new item enters while a batch result is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE || state_q == ST_EMIT) |-> !in_ready)
		else $error("input ready during batch processing");

	// the result is released only from the emit state
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == ST_IDLE)
		else $error("load without return to idle");

endmodule

`default_nettype wire

/* src/fsfa_dp.sv */
// ----------------------------------------------------------------------------
// fsfa_dp - datapath for the flow sensor frame accumulator
// Frame byte tracking, motion/quality sums, serial quality divider,
// quality scaling and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfa_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  fsfa_pkg::dp_cmd_t    cmd,
	output fsfa_pkg::dp_status_t status,
	input  wire  [7:0]           rx_byte,
	input  wire                  out_ready,
	output logic                 out_valid,
	output logic [31:0]          x_motion_sum,
	output logic [31:0]          y_motion_sum,
	output logic [15:0]          frame_total,
	output logic [7:0]           quality_score
);
	import fsfa_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS);

	// frame tracking
	logic [3:0]  pos_q;
	logic [7:0]  x_lo_q, x_hi_q, y_lo_q, y_hi_q, qual_q;

	// batch sums
	logic [31:0] x_acc_q, y_acc_q;
	logic [15:0] qsum_q, cnt_q;

	// divider
	logic [15:0]       rem_q, quo_q;
	logic [STEP_W-1:0] step_q;
	logic [16:0]       rem_shift;
	logic              rem_ge;
	logic [16:0]       rem_diff;

	// output register
	logic        out_valid_q;
	logic [31:0] x_out_q, y_out_q;
	logic [15:0] cnt_out_q;
	logic [7:0]  qual_out_q;

	logic        frame_done;
	logic [31:0] x_ext, y_ext;
	logic [3:0]  qual_idx;

	assign frame_done = cmd.take_byte && pos_q == POS_LAST && rx_byte == FRAME_FOOTER;
	assign x_ext      = {{16{x_hi_q[7]}}, x_hi_q, x_lo_q};
	assign y_ext      = {{16{y_hi_q[7]}}, y_hi_q, y_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (cmd.take_byte) begin
			if (pos_q == POS_IDLE) begin
				if (rx_byte == FRAME_HEADER) begin
					pos_q <= 4'd1;
				end
			end else if (pos_q == POS_LAST) begin
				pos_q <= POS_IDLE;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// payload bytes of the open frame, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			if (pos_q == POS_X_LO) x_lo_q <= rx_byte;
			if (pos_q == POS_X_HI) x_hi_q <= rx_byte;
			if (pos_q == POS_Y_LO) y_lo_q <= rx_byte;
			if (pos_q == POS_Y_HI) y_hi_q <= rx_byte;
			if (pos_q == POS_QUAL) qual_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_acc_q <= '0;
			y_acc_q <= '0;
			qsum_q  <= '0;
			cnt_q   <= '0;
		end else if (cmd.batch_clear || cmd.load_out) begin
			x_acc_q <= '0;
			y_acc_q <= '0;
			qsum_q  <= '0;
			cnt_q   <= '0;
		end else if (frame_done) begin
			x_acc_q <= x_acc_q + x_ext;
			y_acc_q <= y_acc_q + y_ext;
			qsum_q  <= qsum_q + {8'd0, qual_q};
			cnt_q   <= cnt_q + 16'd1;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_shift = {rem_q, quo_q[15]};
	assign rem_diff  = rem_shift - {1'b0, cnt_q};
	assign rem_ge    = rem_shift >= {1'b0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.start_div) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q <= '0;
			quo_q <= qsum_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[15:0] : rem_shift[15:0];
			quo_q <= {quo_q[14:0], rem_ge};
		end
	end

	// clamp the average to the table range
	always_comb begin
		if (quo_q < QUAL_LOW) begin
			qual_idx = 4'd0;
		end else if (quo_q > QUAL_HIGH) begin
			qual_idx = QUAL_SPAN;
		end else begin
			qual_idx = quo_q[3:0] - QUAL_LOW[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			x_out_q    <= x_acc_q;
			y_out_q    <= y_acc_q;
			cnt_out_q  <= cnt_q;
			qual_out_q <= QUAL_SCALE_TABLE[qual_idx];
		end
	end

	assign status.count_zero = cnt_q == 16'd0;
	assign status.div_last   = cmd.div_step && step_q == STEP_W'(DIV_STEPS - 1);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign x_motion_sum  = x_out_q;
	assign y_motion_sum  = y_out_q;
	assign frame_total   = cnt_out_q;
	assign quality_score = qual_out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q && cnt_q == 16'd0)
		else $error("result load did not present output and clear sums");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |-> cnt_q != 16'd0)
		else $error("division started with zero frame count");

	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("byte position beyond frame length");

endmodule

`default_nettype wire

/* src/flow_sensor_frame_accumulator.sv */
// ----------------------------------------------------------------------------
// flow_sensor_frame_accumulator - optical-flow serial frame accumulator
// Parses nine-byte frames (header 0xFE, footer 0xAA), sums x/y motion and
// quality over a batch and reports sums, frame count and quality score.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                         tuser
//  -------  ---  ----------------------------  -------------------------
//  s_*      in   [7:0] rx_byte                 [0] req_type (1 = batch end)
//  m_*      out  [31:0] x_motion_sum           none
//                [63:32] y_motion_sum
//                [79:64] frame_total
//                [87:80] quality_score
//
// - Serial bytes stream back to back while no batch result is in progress.
// - A batch end with frames holds off input while the serial quality
//   divider runs and until the output register is loaded (which waits
//   while that register still holds an untaken result).
// - An empty batch clears the sums and gives no transaction.
// - Input is taken while a loaded result waits on m_tready, if no batch is in progress.
// - arst_n clears position, sums and output valid; frame bytes need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_sensor_frame_accumulator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire  [0:0]  s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [87:0] m_tdata    // x_motion_sum, y_motion_sum, frame_total,
	                               // quality_score, lowest first
);
	import fsfa_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	logic [31:0] x_sum, y_sum;
	logic [15:0] total;
	logic [7:0]  quality;

	// sequencer: decides per cycle what the datapath does
	fsfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser[0]),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: frame parse, sums, divider and output register
	fsfa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.rx_byte       (s_tdata),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.x_motion_sum  (x_sum),
		.y_motion_sum  (y_sum),
		.frame_total   (total),
		.quality_score (quality)
	);

	assign m_tdata = {quality, total, y_sum, x_sum};

endmodule

`default_nettype wire
